### hdl/u8v_pkg.sv
// shared types, constants and helpers for the utf-8 stream validator
package u8v_pkg;

  localparam int CountBits = 16;

  localparam logic [4:0] Width7  = 5'd7;
  localparam logic [4:0] Width8  = 5'd8;
  localparam logic [4:0] Width16 = 5'd16;
  localparam logic [4:0] Width21 = 5'd21;

  localparam logic [20:0] BomValue = 21'h00feff;
  localparam logic [20:0] Lim8     = 21'h000080;
  localparam logic [20:0] Lim16    = 21'h000100;
  localparam logic [20:0] Lim21    = 21'h010000;

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
  localparam logic [31:0] OutCountMax = 32'h0000_ffff;

  typedef struct packed {
    logic [1:0]           expect_cnt;
    logic [20:0]          partial;
    logic [CountBits-1:0] count;
    logic [4:0]           width;
    logic                 err;
  } u8v_state_t;

  typedef struct packed {
    logic        encoding_error;
    logic [15:0] codepoint_count;
    logic [4:0]  max_width;
  } u8v_result_t;

  function automatic logic [15:0] clamp_count(input logic [CountBits-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    return (wide > OutCountMax) ? 16'hffff : wide[15:0];
  endfunction

  function automatic u8v_state_t reset_state();
    u8v_state_t s;
    s.expect_cnt = 2'd0;
    s.partial    = 21'd0;
    s.count      = '0;
    s.width      = Width7;
    s.err        = 1'b0;
    return s;
  endfunction

endpackage

### hdl/u8v_step.sv
// per-byte state update and end-of-string result formatting
module u8v_step (
  input  u8v_pkg::u8v_state_t  cur_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 byte_present_i,
  input  logic                 end_of_string_i,
  output u8v_pkg::u8v_state_t  next_o,
  output u8v_pkg::u8v_result_t result_o
);
  import u8v_pkg::*;

  u8v_state_t  after_byte;
  logic [20:0] cp;
  logic        finish;
  logic [4:0]  new_width;

  always_comb begin
    after_byte = cur_i;
    finish     = 1'b0;
    cp         = {13'd0, data_byte_i};
    if (byte_present_i && !cur_i.err) begin
      if (cur_i.expect_cnt != 2'd0) begin
        if (data_byte_i[7:6] != 2'b10) begin
          after_byte.err = 1'b1;
        end else begin
          cp = {cur_i.partial[14:0], data_byte_i[5:0]};
          after_byte.partial    = cp;
          after_byte.expect_cnt = cur_i.expect_cnt - 2'd1;
          finish = (cur_i.expect_cnt == 2'd1);
        end
      end else if (data_byte_i[7] == 1'b0) begin
        cp     = {14'd0, data_byte_i[6:0]};
        finish = 1'b1;
      end else if (data_byte_i[7:5] == 3'b110) begin
        after_byte.partial    = {16'd0, data_byte_i[4:0]};
        after_byte.expect_cnt = 2'd1;
      end else if (data_byte_i[7:4] == 4'b1110) begin
        after_byte.partial    = {17'd0, data_byte_i[3:0]};
        after_byte.expect_cnt = 2'd2;
      end else if (data_byte_i[7:3] == 5'b11110) begin
        after_byte.partial    = {18'd0, data_byte_i[2:0]};
        after_byte.expect_cnt = 2'd3;
      end else begin
        after_byte.err = 1'b1;
      end
    end

    // widen the class, bom excluded
    new_width = cur_i.width;
    if (cp != BomValue) begin
      if (cp >= Lim21) begin
        new_width = Width21;
      end else if (cp >= Lim16 && cur_i.width < Width16) begin
        new_width = Width16;
      end else if (cp >= Lim8 && cur_i.width < Width8) begin
        new_width = Width8;
      end
    end
    if (finish) begin
      after_byte.width = new_width;
      if (cur_i.count != CountMax) begin
        after_byte.count = cur_i.count + 1'b1;
      end
    end

    if (after_byte.err || after_byte.expect_cnt != 2'd0) begin
      result_o.encoding_error  = 1'b1;
      result_o.codepoint_count = 16'd0;
      result_o.max_width       = Width7;
    end else begin
      result_o.encoding_error  = 1'b0;
      result_o.codepoint_count = clamp_count(after_byte.count);
      result_o.max_width       = after_byte.width;
    end

    next_o = end_of_string_i ? reset_state() : after_byte;
  end

endmodule

### hdl/utf8_stream_validator.sv
// top level: input register, state update and result register
// a request marked end of string is held in the input register, then its result is written to the result register
// throughput: one byte request per cycle while the input is not stalled, set by the single state update path
// a held result stalls the input only when the waiting request would make a result
// reset clears the input and result valids and the state (count 0, width 7, no error)
module utf8_stream_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_string_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        encoding_error_o,
  output logic [15:0] codepoint_count_o,
  output logic [4:0]  max_width_o
);
  import u8v_pkg::*;

  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_byte_q;
  logic        s1_present_q;
  logic        s1_eos_q;
  logic        fire;
  logic        take_in;

  u8v_state_t  state_q, state_d;
  u8v_state_t  step_next;
  u8v_result_t step_res;

  logic        out_valid_q, out_valid_d;
  u8v_result_t out_q;

  u8v_step u_step (
    .cur_i          (state_q),
    .data_byte_i    (s1_byte_q),
    .byte_present_i (s1_present_q),
    .end_of_string_i(s1_eos_q),
    .next_o         (step_next),
    .result_o       (step_res)
  );

  // the held request moves on unless it needs the result slot and the slot is blocked
  assign fire       = s1_valid_q && (!s1_eos_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !fire;
  assign take_in    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = take_in ? 1'b1 : (fire ? 1'b0 : s1_valid_q);
    state_d    = fire ? step_next : state_q;
    if (fire && s1_eos_q) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= reset_state();
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      s1_byte_q    <= data_byte_i;
      s1_present_q <= byte_present_i;
      s1_eos_q     <= end_of_string_i;
    end
    if (fire && s1_eos_q) begin
      out_q <= step_res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign encoding_error_o  = out_q.encoding_error;
  assign codepoint_count_o = out_q.codepoint_count;
  assign max_width_o       = out_q.max_width;

endmodule

### sim/utf8_checker.sv
// watches both channels of the utf-8 validator, predicts each string summary and compares
`timescale 1ns / 1ps

module utf8_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_string_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        encoding_error_i,
  input  logic [15:0] codepoint_count_i,
  input  logic [4:0]  max_width_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_checked_o,
  output int          bad_strings_o
);
  import u8v_pkg::*;

  // predicted validator state for the string in progress
  logic [1:0]           cont_due;
  logic [20:0]          cp_accum;
  logic [CountBits-1:0] cp_count;
  logic [4:0]           widest;
  logic                 seq_broken;

  u8v_result_t expected_summaries[$];
  int          mismatches;
  int          results_seen;
  int          bad_strings;

  task automatic clear_string();
    cont_due   = 2'd0;
    cp_accum   = 21'd0;
    cp_count   = '0;
    widest     = Width7;
    seq_broken = 1'b0;
  endtask

  task automatic tally_codepoint(input logic [20:0] cp);
    // the byte order mark counts but never widens the class
    if (cp != BomValue) begin
      if (cp >= Lim21) begin
        widest = Width21;
      end else if (cp >= Lim16 && widest < Width16) begin
        widest = Width16;
      end else if (cp >= Lim8 && widest < Width8) begin
        widest = Width8;
      end
    end
    if (cp_count != CountMax) begin
      cp_count = cp_count + 1'b1;
    end
  endtask

  task automatic take_utf8_byte(input logic [7:0] b);
    if (!seq_broken) begin
      if (cont_due != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          seq_broken = 1'b1;
        end else begin
          cp_accum = {cp_accum[14:0], b[5:0]};
          cont_due = cont_due - 2'd1;
          if (cont_due == 2'd0) begin
            tally_codepoint(cp_accum);
          end
        end
      end else if (!b[7]) begin
        tally_codepoint({14'd0, b[6:0]});
      end else if (b[7:5] == 3'b110) begin
        cp_accum = {16'd0, b[4:0]};
        cont_due = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        cp_accum = {17'd0, b[3:0]};
        cont_due = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        cp_accum = {18'd0, b[2:0]};
        cont_due = 2'd3;
      end else begin
        seq_broken = 1'b1;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    u8v_result_t want;
    logic [31:0] wide_count;
    if (!rst_ni) begin
      clear_string();
      expected_summaries.delete();
      mismatches   = 0;
      results_seen = 0;
      bad_strings  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (expected_summaries.size() == 0) begin
          mismatches++;
          $error("unexpected result: encoding_error %0d codepoint_count %0d max_width %0d",
                 encoding_error_i, codepoint_count_i, max_width_i);
        end else begin
          want = expected_summaries.pop_front();
          if (encoding_error_i !== want.encoding_error) begin
            mismatches++;
            $error("encoding_error: expected %0d, actual %0d",
                   want.encoding_error, encoding_error_i);
          end
          if (codepoint_count_i !== want.codepoint_count) begin
            mismatches++;
            $error("codepoint_count: expected %0d, actual %0d",
                   want.codepoint_count, codepoint_count_i);
          end
          if (max_width_i !== want.max_width) begin
            mismatches++;
            $error("max_width: expected %0d, actual %0d", want.max_width, max_width_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (byte_present_i) begin
          take_utf8_byte(data_byte_i);
        end
        if (end_of_string_i) begin
          // an open sequence at the end counts as a broken string
          if (seq_broken || cont_due != 2'd0) begin
            want.encoding_error  = 1'b1;
            want.codepoint_count = 16'd0;
            want.max_width       = Width7;
            bad_strings++;
          end else begin
            wide_count           = 32'(cp_count);
            want.encoding_error  = 1'b0;
            want.codepoint_count = (wide_count[31:16] != 16'd0) ? 16'hffff : wide_count[15:0];
            want.max_width       = widest;
          end
          expected_summaries.push_back(want);
          clear_string();
        end
      end
    end
    fail_count_o      <= mismatches;
    pending_o         <= expected_summaries.size();
    results_checked_o <= results_seen;
    bad_strings_o     <= bad_strings;
  end

endmodule

### sim/tb_utf8_stream_validator.sv
// testbench top: drives byte requests into the utf-8 validator and gives the verdict
`timescale 1ns / 1ps

module tb_utf8_stream_validator;

  localparam int CycleLimit = 200_000;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i     = 8'd0;
  logic        byte_present_i  = 1'b0;
  logic        end_of_string_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic        encoding_error_o;
  logic [15:0] codepoint_count_o;
  logic [4:0]  max_width_o;

  int fail_count;
  int pending;
  int results_checked;
  int bad_strings;

  int cycle_count     = 0;
  int requests_sent   = 0;
  int strings_sent    = 0;
  bit calm            = 1'b0;

  logic [7:0] str_q[$];

  utf8_stream_validator u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .byte_present_i    (byte_present_i),
    .end_of_string_i   (end_of_string_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .encoding_error_o  (encoding_error_o),
    .codepoint_count_o (codepoint_count_o),
    .max_width_o       (max_width_o)
  );

  utf8_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .byte_present_i    (byte_present_i),
    .end_of_string_i   (end_of_string_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .encoding_error_i  (encoding_error_o),
    .codepoint_count_i (codepoint_count_o),
    .max_width_i       (max_width_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .results_checked_o (results_checked),
    .bad_strings_o     (bad_strings)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result-side stall bursts, quiet stretches in between
  initial begin
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(30, 80)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
      if (!calm) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_request(input logic [7:0] b, input logic present, input logic eos);
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    byte_present_i  <= present;
    end_of_string_i <= eos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (present || eos) requests_sent++;
    if (eos) strings_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // sender drops valid and holds off until every summary is back, then waits before going on
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic add_codepoint();
    int cls;
    cls = $urandom_range(1, 4);
    if ($urandom_range(0, 15) == 0) begin
      str_q.push_back(8'hef);
      str_q.push_back(8'hbb);
      str_q.push_back(8'hbf);
    end else begin
      case (cls)
        1: str_q.push_back(8'($urandom_range(0, 127)));
        2: str_q.push_back(8'hc0 | 8'($urandom_range(0, 31)));
        3: str_q.push_back(8'he0 | 8'($urandom_range(0, 15)));
        default: str_q.push_back(8'hf0 | 8'($urandom_range(0, 7)));
      endcase
      repeat (cls - 1) str_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
    end
  endtask

  // one string: mostly well formed, sometimes damaged or plain noise
  task automatic send_random_string();
    int  flavor;
    int  n;
    bit  eos_on_last;
    flavor = $urandom_range(0, 9);
    str_q.delete();
    if (flavor == 3) begin
      repeat ($urandom_range(1, 8)) str_q.push_back(8'($urandom));
    end else begin
      n = $urandom_range(0, 10);
      repeat (n) add_codepoint();
    end
    if (str_q.size() > 0) begin
      case (flavor)
        0: str_q[$urandom_range(0, str_q.size() - 1)] = 8'($urandom);
        1: void'(str_q.pop_back());
        2: str_q.insert($urandom_range(0, str_q.size()), 8'($urandom));
        default: ;
      endcase
    end
    eos_on_last = (str_q.size() > 0) && ($urandom_range(0, 1) == 1);
    foreach (str_q[i]) begin
      if ($urandom_range(0, 11) == 0) push_request(8'($urandom), 1'b0, 1'b0);
      push_request(str_q[i], 1'b1, eos_on_last && (i == str_q.size() - 1));
    end
    if (!eos_on_last) push_request(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int goal;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty string, single ascii with end on the byte, a no-op in the middle
    push_request(8'h00, 1'b0, 1'b1);
    push_request(8'h41, 1'b1, 1'b1);
    push_request(8'h00, 1'b1, 1'b0);
    push_request(8'h7f, 1'b1, 1'b0);
    push_request(8'hff, 1'b0, 1'b0);
    push_request(8'h00, 1'b0, 1'b1);
    // two-byte forms: 8-bit class then 16-bit class
    push_request(8'hc2, 1'b1, 1'b0);
    push_request(8'h80, 1'b1, 1'b1);
    push_request(8'hc3, 1'b1, 1'b0);
    push_request(8'ha9, 1'b1, 1'b0);
    push_request(8'hc4, 1'b1, 1'b0);
    push_request(8'h80, 1'b1, 1'b1);
    // byte order mark alone stays in the 7-bit class
    push_request(8'hef, 1'b1, 1'b0);
    push_request(8'hbb, 1'b1, 1'b0);
    push_request(8'hbf, 1'b1, 1'b1);
    // four-byte maximum
    push_request(8'hf4, 1'b1, 1'b0);
    push_request(8'h8f, 1'b1, 1'b0);
    push_request(8'hbf, 1'b1, 1'b0);
    push_request(8'hbf, 1'b1, 1'b1);
    // stray continuation as lead, 11111xxx lead, broken continuation, cut-off tail
    push_request(8'h80, 1'b1, 1'b1);
    push_request(8'hf8, 1'b1, 1'b0);
    push_request(8'h41, 1'b1, 1'b1);
    push_request(8'hc3, 1'b1, 1'b0);
    push_request(8'h41, 1'b1, 1'b1);
    push_request(8'he2, 1'b1, 1'b0);
    push_request(8'h82, 1'b1, 1'b0);
    push_request(8'h00, 1'b0, 1'b1);
    drain_results();

    goal = requests_sent + 250;
    while (requests_sent < goal) begin
      send_random_string();
      if ($urandom_range(0, 19) == 0) drain_results();
    end
    drain_results();

    goal = requests_sent + 120;
    while (requests_sent < goal) send_random_string();

    calm = 1'b1;
    goal = requests_sent + 120;
    while (requests_sent < goal) send_random_string();

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);

    $display("%0d byte or end requests over %0d strings, %0d summaries checked (%0d malformed)",
             requests_sent, strings_sent, results_checked, bad_strings);
    $display("covered lead and continuation errors, truncation, bom and every width class");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/u8v_pkg.sv
hdl/u8v_step.sv
hdl/utf8_stream_validator.sv
sim/utf8_checker.sv
sim/tb_utf8_stream_validator.sv
